// ===== src/correlation_symbol_demodulator_defines.svh =====
// assertion macros for the correlation symbol demodulator
`ifndef CORRELATION_SYMBOL_DEMODULATOR_DEFINES_SVH
`define CORRELATION_SYMBOL_DEMODULATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/csd_pkg.sv =====
// package: types, constants and coefficients of the correlation symbol demodulator
`default_nettype none

package csd_pkg;

    localparam int SAMPLE_WIDTH       = 16;
    localparam int SAMPLES_PER_SYMBOL = 4;
    localparam int SPS_BITS           = $clog2(SAMPLES_PER_SYMBOL);
    localparam int WIN_LEN            = 5;
    localparam int NUM_TAPS           = WIN_LEN - 1;
    localparam int COEF_W             = 17;
    localparam int PROD_W             = SAMPLE_WIDTH + COEF_W;
    localparam int SUM_W              = PROD_W + $clog2(NUM_TAPS);

    localparam int OFFSET_W  = 2;
    localparam int LENGTH_W  = 13;
    localparam int COUNT_W   = 13;
    localparam int INDEX_W   = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = LENGTH_W;

    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LENGTH = CFG_IDX_W'(1);

    localparam logic [OFFSET_W-1:0] START_OFFSET_RST  = OFFSET_W'(2);
    localparam logic [LENGTH_W-1:0] PACKET_LENGTH_RST = LENGTH_W'(1024);
    localparam logic [COUNT_W-1:0]  COUNT_MAX         = '1;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]       t_coef;
    typedef t_sample [NUM_TAPS-1:0]         t_win;

    // sin(k*pi/8) in Q1.15 for window entries 1..4, entry 0 has weight zero
    localparam t_coef [NUM_TAPS-1:0] TAP_COEF = '{
        t_coef'(32768), t_coef'(30274), t_coef'(23170), t_coef'(12540)
    };

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_re;
        logic signed [SAMPLE_WIDTH-1:0] sample_im;
        logic                           packet_start;
    } t_in_item;

    typedef struct packed {
        logic               data_bit;
        logic [INDEX_W-1:0] bit_index;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic pstart;
        logic dec;
    } t_ctl;

endpackage

`default_nettype wire

// ===== src/csd_front.sv =====
// input stage: sample window, packet sample counter and decision timing
`default_nettype none

module csd_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_adv,
    input  wire csd_pkg::t_in_item              i_item,
    input  wire logic [csd_pkg::OFFSET_W-1:0]   i_start_offset,
    input  wire logic [csd_pkg::LENGTH_W-1:0]   i_packet_length,
    output csd_pkg::t_win                       o_win,
    output csd_pkg::t_ctl                       o_ctl
);
    import csd_pkg::*;

    t_win                r_win;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic [COUNT_W-1:0]  w_n;
    logic [COUNT_W-1:0]  w_rel;
    logic                w_dec;
    t_ctl                r_ctl;

    always_comb begin
        w_n     = i_item.packet_start ? '0 : r_count;
        n_count = (w_n == COUNT_MAX) ? w_n : w_n + COUNT_W'(1);
        w_rel   = w_n - COUNT_W'(i_start_offset);
        w_dec   = (w_n >= COUNT_W'(i_start_offset) + COUNT_W'(NUM_TAPS))
                  && (w_rel[SPS_BITS-1:0] == '0)
                  && (w_n < COUNT_W'(i_packet_length));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ctl     <= '0;
        end else begin
            if (i_accept) begin
                r_count <= n_count;
            end
            if (i_adv) begin
                r_ctl.valid  <= i_accept;
                r_ctl.pstart <= i_accept & i_item.packet_start;
                r_ctl.dec    <= i_accept & w_dec;
            end
        end
    end

    // window entry k+1 of the model sits in tap k, oldest first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_accept) begin
            for (int k = 0; k < NUM_TAPS - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[NUM_TAPS-1] <= i_item.sample_im;
        end
    end

    assign o_win = r_win;
    assign o_ctl = r_ctl;

endmodule

`default_nettype wire

// ===== src/csd_corr.sv =====
// correlator: constant-coefficient products, then sum and sign decision
`default_nettype none

module csd_corr (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire csd_pkg::t_win i_win,
    input  wire csd_pkg::t_ctl i_ctl,
    output csd_pkg::t_ctl      o_ctl,
    output logic               o_decision
);
    import csd_pkg::*;

    logic signed [PROD_W-1:0] n_prod [NUM_TAPS];
    logic signed [PROD_W-1:0] r_prod [NUM_TAPS];
    logic signed [SUM_W-1:0]  n_sum;
    t_ctl                     r_ctl_p;
    t_ctl                     r_ctl_d;
    logic                     r_decision;

    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            n_prod[k] = PROD_W'(i_win[k]) * PROD_W'(TAP_COEF[k]);
        end
        n_sum = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            n_sum = n_sum + SUM_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_p <= '0;
            r_ctl_d <= '0;
        end else if (i_adv) begin
            r_ctl_p <= i_ctl;
            r_ctl_d <= r_ctl_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                r_prod[k] <= n_prod[k];
            end
            // negative correlation difference gives raw bit 0
            r_decision <= ~n_sum[SUM_W-1];
        end
    end

    assign o_ctl      = r_ctl_d;
    assign o_decision = r_decision;

endmodule

`default_nettype wire

// ===== src/csd_pair.sv =====
// differential decoder and output register
`default_nettype none

`include "correlation_symbol_demodulator_defines.svh"

module csd_pair (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_stall,
    input  wire csd_pkg::t_ctl i_ctl,
    input  wire logic          i_decision,
    output logic               o_valid,
    output csd_pkg::t_out_item o_item
);
    import csd_pkg::*;

    logic               r_prev;
    logic               r_have_prev;
    logic [INDEX_W-1:0] r_dcount;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               n_prev;
    logic               n_have_prev;
    logic [INDEX_W-1:0] n_dcount;
    logic               n_out_valid;

    logic               w_hp;
    logic [INDEX_W-1:0] w_dc;

    always_comb begin
        w_hp        = i_ctl.pstart ? 1'b0 : r_have_prev;
        w_dc        = i_ctl.pstart ? '0 : r_dcount;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_dcount    = r_dcount;
        n_out_valid = 1'b0;
        if (i_ctl.valid) begin
            n_prev      = i_ctl.pstart ? 1'b0 : r_prev;
            n_have_prev = w_hp;
            n_dcount    = w_dc;
            if (i_ctl.dec) begin
                n_prev      = i_decision;
                n_have_prev = 1'b1;
                if (w_hp) begin
                    n_out_valid = 1'b1;
                    n_dcount    = w_dc + INDEX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= 1'b0;
            r_have_prev <= 1'b0;
            r_dcount    <= '0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_dcount    <= n_dcount;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out.data_bit  <= (r_prev == i_decision);
            r_out.bit_index <= w_dc;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    `CSD_ASSERT_NEXT(a_state_holds_on_stall, r_out_valid && i_stall, $stable(r_dcount) && $stable(r_prev), "decoder state moved while output stalled")
    `CSD_ASSERT_NEXT(a_no_spurious_result, i_adv && !(i_ctl.valid && i_ctl.dec), !r_out_valid, "result without a decision")
    `CSD_ASSERT_NEXT(a_first_decision_silent, i_adv && i_ctl.valid && i_ctl.pstart, !r_out_valid && (r_dcount == '0), "result on first sample of packet")

endmodule

`default_nettype wire

// ===== src/correlation_symbol_demodulator.sv =====
// o_out_valid rises once a sample has passed the window, product, decision and output registers
// throughput: one sample per cycle, all four register stages advance whenever the output is free
// the input stalls only while a finished result waits on a stalled output
// reset (synchronous, active low) clears window, counters, decoder state and valids,
// and loads start_offset 2 and packet_length 1024
`default_nettype none

module correlation_symbol_demodulator (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire csd_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output csd_pkg::t_out_item                    o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [csd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [csd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import csd_pkg::*;

    logic [OFFSET_W-1:0] r_start_offset;
    logic [LENGTH_W-1:0] r_packet_length;
    logic                w_adv;
    logic                w_accept;
    t_win                w_win;
    t_ctl                w_ctl_s1;
    t_ctl                w_ctl_s3;
    logic                w_decision;

    assign w_adv      = ~o_out_valid | ~i_out_stall;
    assign w_accept   = i_in_valid & w_adv;
    assign o_in_stall = ~w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset  <= START_OFFSET_RST;
            r_packet_length <= PACKET_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_OFFSET:  r_start_offset  <= i_cfg_data[OFFSET_W-1:0];
                CFG_PACKET_LENGTH: r_packet_length <= i_cfg_data[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    csd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_adv           (w_adv),
        .i_item          (i_in_data),
        .i_start_offset  (r_start_offset),
        .i_packet_length (r_packet_length),
        .o_win           (w_win),
        .o_ctl           (w_ctl_s1)
    );

    csd_corr u_corr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_win      (w_win),
        .i_ctl      (w_ctl_s1),
        .o_ctl      (w_ctl_s3),
        .o_decision (w_decision)
    );

    csd_pair u_pair (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_stall    (i_out_stall),
        .i_ctl      (w_ctl_s3),
        .i_decision (w_decision),
        .o_valid    (o_out_valid),
        .o_item     (o_out_data)
    );

endmodule

`default_nettype wire
